### hw/rtl/two_mic_frequency_beamformer_defines.svh
// Assertion macros for the two-mic beamformer.
// Depends on signals named clock and reset in the including module.
`ifndef TWO_MIC_FREQUENCY_BEAMFORMER_DEFINES_SVH
`define TWO_MIC_FREQUENCY_BEAMFORMER_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define TMFB_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// An implication checked in the same cycle.
`define TMFB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/tmfb_pkg.sv
// Shared types and constants of the two-mic beamformer.
// No dependencies.
package tmfb_pkg;

   localparam int DEF_NUM_ANGLES = 8;
   localparam int DEF_NUM_BINS   = 256;
   localparam int RESULT_SLOTS   = 8;
   localparam int QUEUE_DEPTH    = 4;
   localparam int REQ_DATA_W     = 208;
   localparam int RSP_DATA_W     = 80;

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_PROCESS = 1'b1
   } op_type;

   typedef enum logic {
      CSR_Q_VALUE  = 1'b0,
      CSR_WEIGHT_Q = 1'b1
   } csr_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  bin;
      logic [2:0]  angle;
      logic        mic;
      logic [31:0] w_re;
      logic [31:0] w_im;
      logic [31:0] l_re;
      logic [31:0] l_im;
      logic [31:0] r_re;
      logic [31:0] r_im;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

### hw/rtl/tmfb_front.sv
// Front end: accepts request transactions, classifies them and drops out-of-range ones.
// Depends on tmfb_pkg.
module tmfb_front
   import tmfb_pkg::*;
#(
   parameter int NUM_ANGLES = DEF_NUM_ANGLES,
   parameter int NUM_BINS   = DEF_NUM_BINS
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  qstat_type             qstat,
   output logic                  push,
   output item_type              push_item
);

   logic bin_ok;
   logic angle_ok;
   logic keep;

   always_comb begin
      push_item.op    = op_type'(req_tuser);
      push_item.bin   = req_tdata[7:0];
      push_item.angle = req_tdata[10:8];
      push_item.mic   = req_tdata[11];
      push_item.w_re  = req_tdata[43:12];
      push_item.w_im  = req_tdata[75:44];
      push_item.l_re  = req_tdata[107:76];
      push_item.l_im  = req_tdata[139:108];
      push_item.r_re  = req_tdata[171:140];
      push_item.r_im  = req_tdata[203:172];
      bin_ok   = int'(push_item.bin) < NUM_BINS;
      angle_ok = int'(push_item.angle) < NUM_ANGLES;
      case (push_item.op)
         OP_WRITE:   keep = bin_ok && angle_ok;
         OP_PROCESS: keep = bin_ok;
         default:    keep = 1'b0;
      endcase
   end

   assign req_tready = !qstat.full;
   assign push       = req_tvalid && !qstat.full && keep;

endmodule

### hw/rtl/tmfb_queue.sv
// Short queue between the front end and the back end.
// Depends on tmfb_pkg.
module tmfb_queue
   import tmfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output logic      head_valid,
   output item_type  head,
   output qstat_type qstat
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   item_type        q_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign qstat.empty = count_ff == '0;
   assign qstat.full  = count_ff == (PW+1)'(QUEUE_DEPTH);

endmodule

### hw/rtl/tmfb_back.sv
// Back end: weight stores, angle sequencer and the normalized complex multiply pipeline.
// Depends on tmfb_pkg.
module tmfb_back
   import tmfb_pkg::*;
#(
   parameter int NUM_ANGLES = DEF_NUM_ANGLES,
   parameter int NUM_BINS   = DEF_NUM_BINS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  item_type              head,
   output logic                  pop,
   input  logic [4:0]            weight_q,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int COUNT = (NUM_ANGLES < RESULT_SLOTS) ? NUM_ANGLES : RESULT_SLOTS;
   localparam int KW    = (COUNT > 1) ? $clog2(COUNT) : 1;
   localparam int DEPTH = NUM_ANGLES * NUM_BINS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OPA [8] = '{0, 1, 0, 1, 2, 3, 2, 3};
   localparam int OPB [8] = '{4, 5, 5, 4, 6, 7, 7, 6};

   typedef struct packed {
      logic [2:0] angle;
      logic [7:0] bin;
      logic       last;
   } meta_type;

   function automatic logic [4:0] lzc32(logic [31:0] x);
      logic [31:0] v;
      logic [4:0]  n;
      begin
         v = x;
         n = '0;
         if (v[31:16] == '0) begin n[4] = 1'b1; v = v << 16; end
         if (v[31:24] == '0) begin n[3] = 1'b1; v = v << 8; end
         if (v[31:28] == '0) begin n[2] = 1'b1; v = v << 4; end
         if (v[31:30] == '0) begin n[1] = 1'b1; v = v << 2; end
         if (v[31] == 1'b0) begin n[0] = 1'b1; end
         return n;
      end
   endfunction

   function automatic logic [31:0] rescale(logic signed [31:0] p, logic [6:0] e, logic z);
      logic [6:0] sh;
      logic [5:0] l;
      begin
         sh = '0;
         l  = '0;
         if (z) begin
            return '0;
         end
         if (e > 7'd32) begin
            sh = e - 7'd32;
            if (sh > 7'd31) begin
               sh = 7'd31;
            end
            return p >>> sh[4:0];
         end
         l = 6'(7'd32 - e);
         if (l == 6'd32) begin
            return '0;
         end
         return p << l[4:0];
      end
   endfunction

   logic [63:0] mem_l [DEPTH];
   logic [63:0] mem_r [DEPTH];

   logic          advance;
   logic          is_proc;
   logic          last_k;
   logic [KW-1:0] k_ff, k_in;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   logic          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   meta_type      meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta5_ff, meta6_ff;
   meta_type      meta1_in;
   logic [63:0]   wl1_ff, wr1_ff;
   logic [127:0]  dat1_ff;

   logic [31:0]        op1 [8];
   logic [31:0]        op2_ff [8], op3_ff [8];
   logic [31:0]        mag2_in [8], mag2_ff [8];
   logic [7:0]         z2_in, z2_ff, z3_ff, z4_ff;
   logic [4:0]         la3_in [8], la3_ff [8], la4_ff [8];
   logic signed [15:0] top4_in [8], top4_ff [8];
   logic signed [31:0] prod5_in [8], prod5_ff [8];
   logic [6:0]         e5_in [8], e5_ff [8];
   logic [7:0]         zp5_in, zp5_ff;
   logic [31:0]        sc6_in [8], sc6_ff [8];
   logic [31:0]        sum_re, sum_im;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   always_comb begin
      advance  = !rsp_valid_ff || rsp_tready;
      is_proc  = head.op == OP_PROCESS;
      last_k   = k_ff == KW'(COUNT - 1);
      pop      = head_valid && advance && (!is_proc || last_k);
      k_in     = k_ff;
      if (head_valid && advance && is_proc) begin
         k_in = last_k ? '0 : k_ff + 1'b1;
      end
      rd_addr  = AW'(k_ff) * AW'(NUM_BINS) + AW'(head.bin);
      wr_addr  = AW'(head.angle) * AW'(NUM_BINS) + AW'(head.bin);
      meta1_in.angle = 3'(k_ff);
      meta1_in.bin   = head.bin;
      meta1_in.last  = last_k;
   end

   always_ff @(posedge clock) begin
      if (advance && head_valid) begin
         if (!is_proc) begin
            if (head.mic) begin
               mem_r[wr_addr] <= {head.w_im, head.w_re};
            end else begin
               mem_l[wr_addr] <= {head.w_im, head.w_re};
            end
         end
         wl1_ff <= mem_l[rd_addr];
         wr1_ff <= mem_r[rd_addr];
      end
   end

   always_comb begin
      op1[0] = wl1_ff[31:0];
      op1[1] = wl1_ff[63:32];
      op1[2] = wr1_ff[31:0];
      op1[3] = wr1_ff[63:32];
      op1[4] = dat1_ff[31:0];
      op1[5] = dat1_ff[63:32];
      op1[6] = dat1_ff[95:64];
      op1[7] = dat1_ff[127:96];
      for (int i = 0; i < 8; i++) begin
         mag2_in[i] = op1[i][31] ? (~op1[i] + 32'd1) : op1[i];
         z2_in[i]   = op1[i] == '0;
         la3_in[i]  = mag2_ff[i][31] ? 5'd0 : lzc32(mag2_ff[i]) - 5'd1;
         top4_in[i] = 16'((op3_ff[i] << la3_ff[i]) >> 16);
      end
      for (int j = 0; j < 8; j++) begin
         prod5_in[j] = 32'(top4_ff[OPA[j]] * top4_ff[OPB[j]]);
         e5_in[j]    = 7'(la4_ff[OPA[j]]) + 7'(la4_ff[OPB[j]]) + 7'(weight_q);
         zp5_in[j]   = z4_ff[OPA[j]] || z4_ff[OPB[j]];
         sc6_in[j]   = rescale(prod5_ff[j], e5_ff[j], zp5_ff[j]);
      end
      sum_re = sc6_ff[0] - sc6_ff[1] + sc6_ff[4] - sc6_ff[5];
      sum_im = sc6_ff[2] + sc6_ff[3] + sc6_ff[6] + sc6_ff[7];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meta1_ff <= meta1_in;
         dat1_ff  <= {head.r_im, head.r_re, head.l_im, head.l_re};
         meta2_ff <= meta1_ff;
         meta3_ff <= meta2_ff;
         meta4_ff <= meta3_ff;
         meta5_ff <= meta4_ff;
         meta6_ff <= meta5_ff;
         z2_ff    <= z2_in;
         z3_ff    <= z2_ff;
         z4_ff    <= z3_ff;
         zp5_ff   <= zp5_in;
         for (int i = 0; i < 8; i++) begin
            op2_ff[i]   <= op1[i];
            mag2_ff[i]  <= mag2_in[i];
            op3_ff[i]   <= op2_ff[i];
            la3_ff[i]   <= la3_in[i];
            la4_ff[i]   <= la3_ff[i];
            top4_ff[i]  <= top4_in[i];
            prod5_ff[i] <= prod5_in[i];
            e5_ff[i]    <= e5_in[i];
            sc6_ff[i]   <= sc6_in[i];
         end
         rsp_data_ff <= {5'b0, sum_im, sum_re, meta6_ff.bin, meta6_ff.angle};
         rsp_last_ff <= meta6_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (advance) begin
            v1_ff        <= head_valid && is_proc;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            v4_ff        <= v3_ff;
            v5_ff        <= v4_ff;
            v6_ff        <= v5_ff;
            rsp_valid_ff <= v6_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hw/rtl/two_mic_frequency_beamformer.sv
// Top level of the two-mic frequency-domain filter-and-sum beamformer.
// Depends on tmfb_pkg, tmfb_front, tmfb_queue, tmfb_back and the defines header.
//
// A write transaction (tuser 0) loads one complex weight. A process transaction
// (tuser 1) gives min(NUM_ANGLES, 8) responses, one per angle in ascending order, with
// tlast on the final angle; the back end issues one angle per cycle while the response
// output is not stalled, as each weight store has a single read port. Writes to an
// angle or bin out of range, and bins out of range, are dropped without response.
// Weight stores come up undefined; every weight must be written before it is used.
`include "two_mic_frequency_beamformer_defines.svh"

module two_mic_frequency_beamformer
   import tmfb_pkg::*;
#(
   parameter int NUM_ANGLES = DEF_NUM_ANGLES,
   parameter int NUM_BINS   = DEF_NUM_BINS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // bin_index, angle_index, mic_select, weight_real, weight_imag, left_real,
   // left_imag, right_real, right_imag, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic                  req_tuser,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [4:0]            csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_angle, out_bin, out_real, out_imag, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int COUNT = (NUM_ANGLES < RESULT_SLOTS) ? NUM_ANGLES : RESULT_SLOTS;

   logic [4:0] wq_ff, wq_in;
   logic       push;
   item_type   push_item;
   logic       pop;
   logic       head_valid;
   item_type   head;
   qstat_type  qstat;

   always_comb begin
      wq_in = wq_ff;
      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_Q_VALUE:  wq_in = wq_ff;
            CSR_WEIGHT_Q: wq_in = csr_wdata;
            default:      wq_in = wq_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wq_ff <= 5'd15;
      end else begin
         wq_ff <= wq_in;
      end
   end

   tmfb_front #(
      .NUM_ANGLES(NUM_ANGLES),
      .NUM_BINS  (NUM_BINS)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   tmfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_valid(head_valid),
      .head      (head),
      .qstat     (qstat)
   );

   tmfb_back #(
      .NUM_ANGLES(NUM_ANGLES),
      .NUM_BINS  (NUM_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head      (head),
      .pop       (pop),
      .weight_q  (wq_ff),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   `TMFB_ASSERT(a_queue_flags, !(qstat.full && qstat.empty), "Queue is both full and empty.")
   `TMFB_ASSERT_IMP(a_full_stalls, qstat.full, !req_tready, "Ready while queue is full.")
   `TMFB_ASSERT_IMP(a_last_angle, rsp_tvalid && rsp_tlast, rsp_tdata[2:0] == 3'(COUNT - 1), "Last flag on a wrong angle.")

endmodule

### sim/tb_two_mic_frequency_beamformer.sv
// Self-checking testbench for the two-mic frequency beamformer: weight loads and bin
// transactions are predicted in the bench and compared per angle. Depends on tmfb_pkg.
module tb_two_mic_frequency_beamformer;
   import tmfb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;

   typedef struct {
      logic [2:0]  angle;
      logic [7:0]  bin;
      logic [31:0] re;
      logic [31:0] im;
      logic        last;
   } beam_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 0;
   logic csr_we = 0;
   logic csr_index = 0;
   logic [4:0] csr_wdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   item_type  pending[$];
   item_type  in_flight;
   beam_type  beams_due[$];
   logic [31:0] wt_re[8][2][256];
   logic [31:0] wt_im[8][2][256];
   int   loaded_bins[$];
   int   wq_cfg = 15;
   int   errors = 0;
   int   cycle = 0;
   int   hold_cnt = 0;
   bit   hold_req = 0;
   bit   hold_done = 0;

   two_mic_frequency_beamformer u_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   function automatic int norm_shift(logic [31:0] x);
      logic [31:0] mag;
      int n;
      mag = x[31] ? -x : x;
      if (mag[31]) return 0;
      n = 0;
      while (n < 32 && !mag[31-n]) n++;
      return n - 1;
   endfunction

   function automatic logic [31:0] norm_mul(logic [31:0] a, logic [31:0] b);
      int la, lb, d;
      logic [31:0] sa, sb;
      logic signed [15:0] ta, tb;
      logic signed [31:0] p;
      if (a == 0 || b == 0) return 0;
      la = norm_shift(a);
      lb = norm_shift(b);
      sa = a << la;
      sb = b << lb;
      ta = sa[31:16];
      tb = sb[31:16];
      p = ta * tb;
      d = la + lb + wq_cfg - 32;
      if (d > 0) return p >>> ((d > 31) ? 31 : d);
      if (-d >= 32) return 0;
      return p << (-d);
   endfunction

   task automatic predict_beams(item_type it);
      beam_type b;
      logic [31:0] lr, li, rr, ri;
      if (it.op == OP_WRITE) begin
         wt_re[it.angle][it.mic][it.bin] = it.w_re;
         wt_im[it.angle][it.mic][it.bin] = it.w_im;
         return;
      end
      for (int k = 0; k < 8; k++) begin
         lr = norm_mul(wt_re[k][0][it.bin], it.l_re) - norm_mul(wt_im[k][0][it.bin], it.l_im);
         li = norm_mul(wt_re[k][0][it.bin], it.l_im) + norm_mul(wt_im[k][0][it.bin], it.l_re);
         rr = norm_mul(wt_re[k][1][it.bin], it.r_re) - norm_mul(wt_im[k][1][it.bin], it.r_im);
         ri = norm_mul(wt_re[k][1][it.bin], it.r_im) + norm_mul(wt_im[k][1][it.bin], it.r_re);
         b.angle = 3'(k);
         b.bin = it.bin;
         b.re = lr + rr;
         b.im = li + ri;
         b.last = (k == 7);
         beams_due.push_back(b);
      end
   endtask

   task automatic report(string what);
      $display("ERROR at cycle %0d: %s", cycle, what);
      errors++;
   endtask

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= LIMIT) begin
         $display("two_mic_frequency_beamformer: mismatch");
         $finish;
      end
   end

   // Sender side.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_beams(in_flight);
         if (!req_tvalid || req_tready) begin
            if (pending.size() > 0 &&
                ((cycle > 600 && cycle < 1600) || $urandom_range(99) >= 7)) begin
               in_flight = pending.pop_front();
               req_tvalid <= 1;
               req_tuser <= in_flight.op;
               req_tdata <= {4'b0, in_flight.r_im, in_flight.r_re, in_flight.l_im,
                             in_flight.l_re, in_flight.w_im, in_flight.w_re,
                             in_flight.mic, in_flight.angle, in_flight.bin};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // Receiver side.
   always @(posedge clock) begin
      beam_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (beams_due.size() == 0) begin
               report("transaction with nothing expected");
            end else begin
               e = beams_due.pop_front();
               if (rsp_tdata[2:0] !== e.angle)
                  report($sformatf("angle %0d, expected %0d", rsp_tdata[2:0], e.angle));
               if (rsp_tdata[10:3] !== e.bin)
                  report($sformatf("bin %0d, expected %0d", rsp_tdata[10:3], e.bin));
               if (rsp_tdata[42:11] !== e.re)
                  report($sformatf("real %h, expected %h", rsp_tdata[42:11], e.re));
               if (rsp_tdata[74:43] !== e.im)
                  report($sformatf("imag %h, expected %h", rsp_tdata[74:43], e.im));
               if (rsp_tlast !== e.last)
                  report($sformatf("last %b, expected %b", rsp_tlast, e.last));
            end
         end
         if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_cnt <= 300;
            rsp_tready <= 0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= (cycle > 600 && cycle < 1600) || $urandom_range(99) >= 7;
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(6))
         0: return 0;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return -32'sd1;
         4: return $urandom >> $urandom_range(31);
         5: return -($urandom >> $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   task automatic push_write(int bin, int angle, int mic, logic [31:0] re, logic [31:0] im);
      item_type it;
      it = '0;
      it.op = OP_WRITE;
      it.bin = 8'(bin);
      it.angle = 3'(angle);
      it.mic = 1'(mic);
      it.w_re = re;
      it.w_im = im;
      it.l_re = $urandom;
      it.r_im = $urandom;
      pending.push_back(it);
   endtask

   task automatic load_bin(int bin);
      for (int a = 0; a < 8; a++)
         for (int m = 0; m < 2; m++)
            push_write(bin, a, m, pick_value(), pick_value());
      loaded_bins.push_back(bin);
   endtask

   task automatic push_bin(int bin, logic [31:0] lr, logic [31:0] li,
                           logic [31:0] rr, logic [31:0] ri);
      item_type it;
      it = '0;
      it.op = OP_PROCESS;
      it.bin = 8'(bin);
      it.angle = 3'($urandom);
      it.mic = 1'($urandom);
      it.w_re = $urandom;
      it.w_im = $urandom;
      it.l_re = lr;
      it.l_im = li;
      it.r_re = rr;
      it.r_im = ri;
      pending.push_back(it);
   endtask

   task automatic random_items(int count);
      int bin;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: load_bin($urandom_range(255));
            1, 2: begin
               bin = loaded_bins[$urandom_range(loaded_bins.size() - 1)];
               push_write(bin, $urandom_range(7), $urandom_range(1),
                          pick_value(), pick_value());
            end
            default: push_bin(loaded_bins[$urandom_range(loaded_bins.size() - 1)],
                              pick_value(), pick_value(), pick_value(), pick_value());
         endcase
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending.size() > 0 || req_tvalid || beams_due.size() > 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_formats(int q, int wq);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= CSR_Q_VALUE;
      csr_wdata <= 5'(q);
      @(posedge clock);
      csr_index <= CSR_WEIGHT_Q;
      csr_wdata <= 5'(wq);
      @(posedge clock);
      csr_we <= 0;
      wq_cfg = wq;
   endtask

   initial begin
      int q_set[4] = '{15, 31, 0, 9};
      int wq_set[4] = '{15, 0, 31, 22};
      repeat (4) @(posedge clock);
      reset <= 0;
      push_write(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
      push_write(0, 0, 1, 0, 1);
      for (int a = 1; a < 8; a++)
         for (int m = 0; m < 2; m++)
            push_write(0, a, m, pick_value(), pick_value());
      loaded_bins.push_back(0);
      load_bin(255);
      push_bin(0, 0, 0, 0, 0);
      push_bin(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_bin(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_bin(255, -32'sd1, 1, 32'h8000_0000, 32'h7fff_ffff);
      push_bin(255, 1, -32'sd1, 0, 32'h0001_0000);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) set_formats(q_set[ph], wq_set[ph]);
         random_items(ph == 0 ? 15 : 6);
         if (ph == 0) hold_req = 1;
         drain();
      end
      if (errors == 0) begin
         $display("two_mic_frequency_beamformer: match");
      end else begin
         $display("two_mic_frequency_beamformer: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tmfb_pkg.sv
hw/rtl/tmfb_front.sv
hw/rtl/tmfb_queue.sv
hw/rtl/tmfb_back.sv
hw/rtl/two_mic_frequency_beamformer.sv
sim/tb_two_mic_frequency_beamformer.sv
